@@ rtl/core/qrs_pkg.sv @@
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_WIDTH      = 34;
  localparam int KIND_WIDTH     = 2;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_NONE     = 2'd0,
    KIND_DISTINCT = 2'd1,
    KIND_EQUAL    = 2'd2,
    KIND_COMPLEX  = 2'd3
  } root_kind_t;

endpackage

@@ rtl/core/qrs_if.sv @@
interface qrs_coef_if #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if;
  logic                                 valid;
  logic                                 ready;
  logic [qrs_pkg::KIND_WIDTH-1:0]       root_kind;
  logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value;
  logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value;

  modport source(output valid, output root_kind, output first_value, output second_value,
                 input ready);
  modport sink(input valid, input root_kind, input first_value, input second_value,
               output ready);
endinterface

@@ rtl/core/quadratic_root_solver_core.sv @@
// Channel  Role    Payload
// coef     sink    coef_a, coef_b, coef_c (signed, COEF_WIDTH bits each)
// root     source  root_kind, first_value, second_value (signed, FRAC_BITS fraction bits)
//
// One beat is taken every cycle unless the root side stalls.
// The depth is set by the square root, one result bit per stage, followed by two
// restoring dividers that retire one quotient bit per stage.
// Reset clears only the stage valid bits.
// A stall at the root side freezes every stage at once, so no beat is lost or repeated.
module quadratic_root_solver_core #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input logic    clk,
  input logic    rst,
  qrs_coef_if.sink   coef,
  qrs_root_if.source root
);

  localparam int W    = COEF_WIDTH;
  localparam int PW   = 2 * W;
  localparam int DW   = 2 * W + 2;
  localparam int SQ   = W + 1;
  localparam int RADW = 2 * SQ;
  localparam int DN   = W + 1;
  localparam int MW   = W + 2;
  localparam int QW   = MW + FRAC_BITS;
  localparam int OW   = qrs_pkg::OUT_WIDTH;
  localparam int XW   = (QW > OW ? QW : OW) + 1;

  logic en;
  assign en = !root.valid || root.ready;
  assign coef.ready = en;

  // Products.
  logic                va;
  logic signed [W-1:0] a_a, a_b;
  logic signed [PW-1:0] a_bb, a_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= coef.valid;
    end
    if (en) begin
      a_a  <= coef.coef_a;
      a_b  <= coef.coef_b;
      a_bb <= PW'(coef.coef_b) * PW'(coef.coef_b);
      a_ac <= PW'(coef.coef_a) * PW'(coef.coef_c);
    end
  end

  // Discriminant, then square root stages.
  logic                sq_v    [0:SQ];
  logic signed [W-1:0] sq_a    [0:SQ];
  logic signed [W-1:0] sq_b    [0:SQ];
  logic                sq_neg  [0:SQ];
  logic                sq_zero [0:SQ];
  logic [RADW-1:0]     sq_rad  [0:SQ];
  logic [SQ+1:0]       sq_rem  [0:SQ];
  logic [SQ-1:0]       sq_root [0:SQ];

  logic signed [DW-1:0] disc;
  assign disc = DW'(a_bb) - (DW'(a_ac) <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= va;
    end
    if (en) begin
      sq_a[0]    <= a_a;
      sq_b[0]    <= a_b;
      sq_neg[0]  <= disc[DW-1];
      sq_zero[0] <= (disc == '0);
      sq_rad[0]  <= RADW'(disc[DW-1] ? -disc : disc);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [SQ+1:0] rem_sh, trial, diff;
    logic          ge;

    assign rem_sh = {sq_rem[k][SQ-1:0], sq_rad[k][RADW-1 -: 2]};
    assign trial  = {sq_root[k], 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (en) begin
        sq_a[k+1]    <= sq_a[k];
        sq_b[k+1]    <= sq_b[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_zero[k+1] <= sq_zero[k];
        sq_rad[k+1]  <= sq_rad[k] << 2;
        sq_rem[k+1]  <= ge ? diff : rem_sh;
        sq_root[k+1] <= {sq_root[k][SQ-2:0], ge};
      end
    end
  end

  // Numerators, denominator and signs.
  logic signed [MW:0] st_nb, st_s, st_n1, st_n2;
  logic [W-1:0]       st_abs_a;
  qrs_pkg::root_kind_t st_kind;

  always_comb begin
    st_nb    = -((MW+1)'(sq_b[SQ]));
    st_s     = $signed({2'b00, sq_root[SQ]});
    st_n1    = sq_neg[SQ] ? st_nb : st_nb + st_s;
    st_n2    = sq_neg[SQ] ? st_s : st_nb - st_s;
    st_abs_a = sq_a[SQ][W-1] ? W'(-sq_a[SQ]) : W'(sq_a[SQ]);
    if (sq_a[SQ] == '0) begin
      st_kind = qrs_pkg::KIND_NONE;
    end else if (sq_neg[SQ]) begin
      st_kind = qrs_pkg::KIND_COMPLEX;
    end else if (sq_zero[SQ]) begin
      st_kind = qrs_pkg::KIND_EQUAL;
    end else begin
      st_kind = qrs_pkg::KIND_DISTINCT;
    end
  end

  logic                dv_v    [0:QW];
  qrs_pkg::root_kind_t dv_kind [0:QW];
  logic                dv_s1   [0:QW];
  logic                dv_s2   [0:QW];
  logic [DN-1:0]       dv_den  [0:QW];
  logic [QW-1:0]       dv_n1   [0:QW];
  logic [QW-1:0]       dv_n2   [0:QW];
  logic [DN-1:0]       dv_r1   [0:QW];
  logic [DN-1:0]       dv_r2   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQ];
    end
    if (en) begin
      dv_kind[0] <= st_kind;
      dv_s1[0]   <= st_n1[MW] ^ sq_a[SQ][W-1];
      dv_s2[0]   <= st_n2[MW] ^ (sq_a[SQ][W-1] & !sq_neg[SQ]);
      dv_den[0]  <= {st_abs_a, 1'b0};
      dv_n1[0]   <= {MW'(st_n1[MW] ? -st_n1 : st_n1), FRAC_BITS'(0)};
      dv_n2[0]   <= {MW'(st_n2[MW] ? -st_n2 : st_n2), FRAC_BITS'(0)};
      dv_r1[0]   <= '0;
      dv_r2[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DN:0] sh1, sh2, df1, df2;
    logic        ge1, ge2;

    assign sh1 = {dv_r1[j], dv_n1[j][QW-1]};
    assign sh2 = {dv_r2[j], dv_n2[j][QW-1]};
    assign ge1 = sh1 >= {1'b0, dv_den[j]};
    assign ge2 = sh2 >= {1'b0, dv_den[j]};
    assign df1 = sh1 - {1'b0, dv_den[j]};
    assign df2 = sh2 - {1'b0, dv_den[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (en) begin
        dv_kind[j+1] <= dv_kind[j];
        dv_s1[j+1]   <= dv_s1[j];
        dv_s2[j+1]   <= dv_s2[j];
        dv_den[j+1]  <= dv_den[j];
        dv_n1[j+1]   <= {dv_n1[j][QW-2:0], ge1};
        dv_n2[j+1]   <= {dv_n2[j][QW-2:0], ge2};
        dv_r1[j+1]   <= ge1 ? df1[DN-1:0] : sh1[DN-1:0];
        dv_r2[j+1]   <= ge2 ? df2[DN-1:0] : sh2[DN-1:0];
      end
    end
  end

  // Saturation into the output register.
  localparam logic [XW-1:0] LIM = XW'(1) << (OW - 1);

  logic [XW-1:0] q1, q2, c1, c2;
  logic [OW-1:0] v1, v2;

  always_comb begin
    q1 = XW'(dv_n1[QW]);
    q2 = XW'(dv_n2[QW]);
    if (dv_s1[QW]) begin
      c1 = (q1 > LIM) ? LIM : q1;
      v1 = OW'(-c1);
    end else begin
      c1 = (q1 > LIM - XW'(1)) ? LIM - XW'(1) : q1;
      v1 = OW'(c1);
    end
    if (dv_s2[QW]) begin
      c2 = (q2 > LIM) ? LIM : q2;
      v2 = OW'(-c2);
    end else begin
      c2 = (q2 > LIM - XW'(1)) ? LIM - XW'(1) : q2;
      v2 = OW'(c2);
    end
    if (dv_kind[QW] == qrs_pkg::KIND_NONE) begin
      v1 = '0;
      v2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root.valid <= 1'b0;
    end else if (en) begin
      root.valid <= dv_v[QW];
    end
    if (en) begin
      root.root_kind    <= dv_kind[QW];
      root.first_value  <= v1;
      root.second_value <= v2;
    end
  end

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    root.valid && root.root_kind == qrs_pkg::KIND_NONE |->
      root.first_value == '0 && root.second_value == '0)
    else $error("non-quadratic beat carries nonzero values");

  a_equal_same: assert property (@(posedge clk) disable iff (rst)
    root.valid && root.root_kind == qrs_pkg::KIND_EQUAL |->
      root.first_value == root.second_value)
    else $error("equal roots differ");

  a_imag_pos: assert property (@(posedge clk) disable iff (rst)
    root.valid && root.root_kind == qrs_pkg::KIND_COMPLEX |-> !root.second_value[OW-1])
    else $error("negative imaginary magnitude");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    root.valid && !root.ready |-> !coef.ready)
    else $error("input taken while output stalled");

endmodule

@@ verif/quadratic_root_solver_core_tb.sv @@
module quadratic_root_solver_core_tb;

  localparam int CW = qrs_pkg::COEF_WIDTH_DEF;
  localparam int FB = qrs_pkg::FRAC_BITS_DEF;
  localparam int OW = qrs_pkg::OUT_WIDTH;
  localparam int LATENCY = CW + FB + CW + 7;
  localparam int RANDOM_BEATS = 1800;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coef_t;

  typedef struct packed {
    qrs_pkg::root_kind_t   kind;
    logic signed [OW-1:0]  first;
    logic signed [OW-1:0]  second;
  } roots_t;

  typedef struct {
    coef_t  coef;
    bit     typed;
    roots_t roots;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrs_coef_if coef_ch ();
  qrs_root_if root_ch ();

  quadratic_root_solver_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .coef (coef_ch.sink),
    .root (root_ch.source)
  );

  roots_t pending_roots[$];
  int     mismatches = 0;
  int     beats_in = 0;
  bit     hold_off = 1'b0;
  bit     sending_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned m);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > m) b = b >> 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m = m - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [OW-1:0] scaled_quotient(longint num, longint unsigned den,
                                                     bit den_neg);
    bit              num_neg;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned lim;
    num_neg = num < 0;
    mag = num_neg ? longint'(-num) : longint'(num);
    q = (mag << FB) / den;
    lim = 64'd1 << (OW - 1);
    if ((num_neg != den_neg) && q != 0) begin
      if (q > lim) q = lim;
      return OW'(-q);
    end
    if (q > lim - 1) q = lim - 1;
    return OW'(q);
  endfunction

  function automatic roots_t solve_roots(coef_t k);
    longint          a;
    longint          b;
    longint          c;
    longint          disc;
    longint          s;
    longint unsigned den;
    roots_t          r;
    a = k.a;
    b = k.b;
    c = k.c;
    if (a == 0) begin
      r.kind = qrs_pkg::KIND_NONE;
      r.first = '0;
      r.second = '0;
      return r;
    end
    disc = b * b - 4 * a * c;
    den = 2 * ((a < 0) ? -a : a);
    if (disc >= 0) begin
      s = floor_sqrt(disc);
      r.kind = (disc == 0) ? qrs_pkg::KIND_EQUAL : qrs_pkg::KIND_DISTINCT;
      r.first = scaled_quotient(-b + s, den, a < 0);
      r.second = scaled_quotient(-b - s, den, a < 0);
    end else begin
      s = floor_sqrt(-disc);
      r.kind = qrs_pkg::KIND_COMPLEX;
      r.first = scaled_quotient(-b, den, a < 0);
      r.second = scaled_quotient(s, den, 1'b0);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [CW-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return CW'($signed($urandom_range(0, 16)) - 8);
      3: return CW'($signed($urandom_range(0, 512)) - 256);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic coef_t pick_item();
    coef_t k;
    int    p;
    int    q;
    case ($urandom_range(0, 9))
      0: begin
        k.a = '0;
        k.b = pick_coef();
        k.c = pick_coef();
      end
      1, 2: begin
        p = $urandom_range(1, 181);
        q = $urandom_range(0, (p > 90) ? 16383 / p : 181);
        k.a = ($urandom_range(0, 1) ? -1 : 1) * p * p;
        k.b = ($urandom_range(0, 1) ? -2 : 2) * p * q;
        k.c = (k.a < 0) ? -q * q : q * q;
      end
      default: begin
        k.a = pick_coef();
        k.b = pick_coef();
        k.c = pick_coef();
      end
    endcase
    return k;
  endfunction

  task automatic send_beat(coef_t k);
    coef_ch.valid <= 1'b1;
    coef_ch.coef_a <= k.a;
    coef_ch.coef_b <= k.b;
    coef_ch.coef_c <= k.c;
    do @(posedge clk); while (!coef_ch.ready);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      coef_ch.valid <= 1'b0;
      coef_ch.coef_a <= CW'($urandom);
      coef_ch.coef_b <= CW'($urandom);
      coef_ch.coef_c <= CW'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  stim_row_t directed[$];

  task automatic add_row(int a, int b, int c, bit typed = 1'b0,
                         qrs_pkg::root_kind_t kind = qrs_pkg::KIND_NONE,
                         longint v1 = 0, longint v2 = 0);
    stim_row_t row;
    row.coef.a = CW'(a);
    row.coef.b = CW'(b);
    row.coef.c = CW'(c);
    row.typed = typed;
    row.roots.kind = kind;
    row.roots.first = OW'(v1);
    row.roots.second = OW'(v2);
    directed.push_back(row);
  endtask

  initial begin
    coef_t  k;
    roots_t r;
    coef_ch.valid = 1'b0;
    coef_ch.coef_a = '0;
    coef_ch.coef_b = '0;
    coef_ch.coef_c = '0;
    add_row(0, 0, 0, 1'b1, qrs_pkg::KIND_NONE, 0, 0);
    add_row(0, -32768, 32767, 1'b1, qrs_pkg::KIND_NONE, 0, 0);
    add_row(0, 32767, -32768, 1'b1, qrs_pkg::KIND_NONE, 0, 0);
    add_row(1, 0, 0, 1'b1, qrs_pkg::KIND_EQUAL, 0, 0);
    add_row(1, -2, 1, 1'b1, qrs_pkg::KIND_EQUAL, 65536, 65536);
    add_row(1, -3, 2, 1'b1, qrs_pkg::KIND_DISTINCT, 2 * 65536, 65536);
    add_row(1, 0, 1, 1'b1, qrs_pkg::KIND_COMPLEX, 0, 65536);
    add_row(-1, 0, 4, 1'b1, qrs_pkg::KIND_DISTINCT, -2 * 65536, 2 * 65536);
    add_row(2, 1, -3);
    add_row(3, 5, 7);
    add_row(-32768, -32768, -32768);
    add_row(-32768, 32767, 32767);
    add_row(32767, 32767, 32767);
    add_row(32767, -32768, -32768);
    add_row(1, -32768, -32768);
    add_row(-1, 32767, 32767);
    add_row(1, 32767, -32768);
    add_row(-1, -32768, 32767);
    add_row(1, 1, 1);
    add_row(-1, -1, -1);
    add_row(4, 4, 1);
    add_row(-7, 3, 0);
    add_row(32767, 0, 1);
    add_row(1, 0, 32767);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      r = directed[i].typed ? directed[i].roots : solve_roots(directed[i].coef);
      pending_roots.push_back(r);
      send_beat(directed[i].coef);
      idle_sender(pick_gap());
    end
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      k = pick_item();
      pending_roots.push_back(solve_roots(k));
      send_beat(k);
      if (n % 300 < 200) idle_sender(pick_gap());
    end
    coef_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    wait (beats_in == 600);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int gap;
    root_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        root_ch.ready <= 1'b0;
        @(negedge clk);
      end else begin
        gap = pick_gap();
        root_ch.ready <= (gap == 0) || (beats_in % 500 > 400);
        @(negedge clk);
        if (gap > 0 && beats_in % 500 <= 400) begin
          repeat (gap - 1) @(negedge clk);
          root_ch.ready <= 1'b1;
          @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    roots_t want;
    if (!rst && root_ch.valid && root_ch.ready) begin
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result beat with nothing expected.");
      end else begin
        want = pending_roots.pop_front();
        if (root_ch.root_kind !== want.kind || root_ch.first_value !== want.first
            || root_ch.second_value !== want.second) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected kind %0d values %0d %0d, got kind %0d values %0d %0d",
                     want.kind, want.first, want.second, root_ch.root_kind,
                     root_ch.first_value, root_ch.second_value);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
